/* src/rthsv_pkg.sv */
// ----------------------------------------------------------------------------
// rthsv_pkg
// Shared types and constants for the RGB to HSV pixel converter: widths,
// hue sector codes, the queue entry and the queue status group.
// ----------------------------------------------------------------------------
package rthsv_pkg;

  // channel and result widths
  localparam int CH_W      = 8;
  localparam int HUE_W     = 9;
  // divisors are twice a channel byte
  localparam int DIV_W     = CH_W + 1;
  // saturation numerator 510*d + max, at most 130305
  localparam int SAT_NUM_W = 17;
  // hue numerator 120*diff + 121*d, at most 61455
  localparam int HUE_NUM_W = 16;
  // both quotients fit in one byte, one divider step per quotient bit
  localparam int QUO_W     = 8;
  localparam int STAGES    = QUO_W;

  // arithmetic constants
  localparam int SAT_SCALE2 = 510;
  localparam int HUE_SPAN   = 120;
  localparam int HUE_BIAS   = 121;
  localparam int FULL_TURN  = 360;

  // hue offset per sector, with the 60 degree bias of the numerator removed
  localparam logic [HUE_W-1:0] OFF_RED   = 9'd300;
  localparam logic [HUE_W-1:0] OFF_GREEN = 9'd60;
  localparam logic [HUE_W-1:0] OFF_BLUE  = 9'd180;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // classified pixel waiting for division
  typedef struct packed {
    logic [SAT_NUM_W-1:0] sat_num;
    logic [DIV_W-1:0]     sat_div;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [DIV_W-1:0]     hue_div;
    sector_t              sector;
    logic                 gray;
    logic                 black;
    logic [CH_W-1:0]      value;
  } item_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic not_empty;
    logic can_push;
  } queue_stat_t;

  function automatic logic [HUE_W-1:0] hue_offset(input sector_t s);
    logic [HUE_W-1:0] off;
    case (s)
      SECT_RED:   off = OFF_RED;
      SECT_GREEN: off = OFF_GREEN;
      SECT_BLUE:  off = OFF_BLUE;
      default:    off = '0;
    endcase
    return off;
  endfunction

endpackage

/* src/rthsv_front.sv */
// ----------------------------------------------------------------------------
// rthsv_front
// Accepts a pixel, finds max, min and hue sector, and forms the numerators
// and divisors for saturation and hue. Holds its beat until the queue takes it.
// ----------------------------------------------------------------------------
module rthsv_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  rthsv_pkg::queue_stat_t qstat,
  output logic                 busy,
  output logic                 item_valid,
  output rthsv_pkg::item_t     item
);
  import rthsv_pkg::*;

  localparam int WIDE_W = HUE_NUM_W + 2;
  localparam logic signed [WIDE_W-1:0] SPAN_S = WIDE_W'(HUE_SPAN);
  localparam logic signed [WIDE_W-1:0] BIAS_S = WIDE_W'(HUE_BIAS);

  logic [CH_W-1:0]          mx;
  logic [CH_W-1:0]          mn;
  logic [CH_W-1:0]          d;
  sector_t                  sector;
  logic signed [CH_W:0]     diff;
  logic signed [WIDE_W-1:0] diff_x;
  logic signed [WIDE_W-1:0] d_x;
  logic signed [WIDE_W-1:0] hue_wide;
  item_t                    item_next;

  // max picks red first, then green, then blue
  always_comb begin
    if (red >= green && red >= blue) begin
      mx     = red;
      sector = SECT_RED;
      diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      mx     = green;
      sector = SECT_GREEN;
      diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      mx     = blue;
      sector = SECT_BLUE;
      diff   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  // min of the three channels
  always_comb begin
    if (red <= green && red <= blue) begin
      mn = red;
    end else if (green <= blue) begin
      mn = green;
    end else begin
      mn = blue;
    end
  end

  assign d = mx - mn;

  // hue numerator shifted by 60 degrees so it never goes negative
  assign diff_x   = WIDE_W'(diff);
  assign d_x      = $signed(WIDE_W'(d));
  assign hue_wide = diff_x * SPAN_S + d_x * BIAS_S;

  always_comb begin
    item_next.sat_num = SAT_NUM_W'(d) * SAT_NUM_W'(SAT_SCALE2) + SAT_NUM_W'(mx);
    item_next.sat_div = {mx, 1'b0};
    item_next.hue_num = hue_wide[HUE_NUM_W-1:0];
    item_next.hue_div = {d, 1'b0};
    item_next.sector  = sector;
    item_next.gray    = (d == '0);
    item_next.black   = (mx == '0);
    item_next.value   = mx;
  end

  // stall only while the held beat cannot move into the queue
  assign busy = item_valid && !qstat.can_push;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (qstat.can_push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

/* src/rthsv_queue.sv */
// ----------------------------------------------------------------------------
// rthsv_queue
// Short first-in first-out queue between the classifier and the divider
// pipeline. The back part takes the head whenever the queue is not empty.
// ----------------------------------------------------------------------------
module rthsv_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  input  rthsv_pkg::item_t       push_item,
  output rthsv_pkg::queue_stat_t qstat,
  output rthsv_pkg::item_t       head
);
  import rthsv_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign pop             = (count != '0);
  assign qstat.not_empty = pop;
  assign qstat.can_push  = (count != CW'(DEPTH)) || pop;
  assign push            = push_valid && qstat.can_push;
  assign head            = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/rthsv_divpipe.sv */
// ----------------------------------------------------------------------------
// rthsv_divpipe
// Back part: two restoring dividers side by side, one quotient bit per
// stage, followed by the hue sector offset, wrap and the result register.
// ----------------------------------------------------------------------------
module rthsv_divpipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  rthsv_pkg::item_t              head,
  output logic                          strobe,
  output logic [rthsv_pkg::HUE_W-1:0]   hue,
  output logic [rthsv_pkg::CH_W-1:0]    saturation,
  output logic [rthsv_pkg::CH_W-1:0]    brightness
);
  import rthsv_pkg::*;

  typedef struct packed {
    logic [SAT_NUM_W-1:0] rem_s;
    logic [HUE_NUM_W-1:0] rem_h;
    logic [DIV_W-1:0]     div_s;
    logic [DIV_W-1:0]     div_h;
    logic [QUO_W-1:0]     q_s;
    logic [QUO_W-1:0]     q_h;
    sector_t              sector;
    logic                 gray;
    logic                 black;
    logic [CH_W-1:0]      value;
  } stage_t;

  stage_t              cur  [STAGES];
  stage_t              nxt  [STAGES];
  stage_t              pipe [STAGES];
  logic [STAGES-1:0]   cur_v;
  logic [STAGES-1:0]   pipe_v;
  stage_t              last;
  logic [HUE_W:0]      hue_sum;
  logic [HUE_W-1:0]    hue_next;

  genvar k;
  generate
    for (k = 0; k < STAGES; k++) begin : g_stage
      localparam int BIT = STAGES - 1 - k;
      logic [SAT_NUM_W-1:0] sh_s;
      logic [HUE_NUM_W-1:0] sh_h;

      // stage input
      if (k == 0) begin : g_first
        always_comb begin
          cur[k].rem_s  = head.sat_num;
          cur[k].rem_h  = head.hue_num;
          cur[k].div_s  = head.sat_div;
          cur[k].div_h  = head.hue_div;
          cur[k].q_s    = '0;
          cur[k].q_h    = '0;
          cur[k].sector = head.sector;
          cur[k].gray   = head.gray;
          cur[k].black  = head.black;
          cur[k].value  = head.value;
        end
        assign cur_v[k] = head_valid;
      end else begin : g_rest
        always_comb begin
          cur[k] = pipe[k-1];
        end
        assign cur_v[k] = pipe_v[k-1];
      end

      // one compare and subtract per divider
      assign sh_s = SAT_NUM_W'(cur[k].div_s) << BIT;
      assign sh_h = HUE_NUM_W'(cur[k].div_h) << BIT;

      always_comb begin
        nxt[k] = cur[k];
        if (cur[k].rem_s >= sh_s) begin
          nxt[k].rem_s    = cur[k].rem_s - sh_s;
          nxt[k].q_s[BIT] = 1'b1;
        end
        if (cur[k].rem_h >= sh_h) begin
          nxt[k].rem_h    = cur[k].rem_h - sh_h;
          nxt[k].q_h[BIT] = 1'b1;
        end
      end

      // stage register
      always_ff @(posedge clk) begin
        if (rst) begin
          pipe_v[k] <= 1'b0;
        end else begin
          pipe_v[k] <= cur_v[k];
        end
      end

      always_ff @(posedge clk) begin
        pipe[k] <= nxt[k];
      end
    end
  endgenerate

  assign last = pipe[STAGES-1];

  // sector offset and wrap of a full turn
  always_comb begin
    hue_sum = (HUE_W + 1)'(last.q_h) + (HUE_W + 1)'(hue_offset(last.sector));
    if (hue_sum >= (HUE_W + 1)'(FULL_TURN)) begin
      hue_sum = hue_sum - (HUE_W + 1)'(FULL_TURN);
    end
    hue_next = last.gray ? '0 : hue_sum[HUE_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= pipe_v[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    hue        <= hue_next;
    saturation <= last.black ? '0 : last.q_s;
    brightness <= last.value;
  end

endmodule

/* src/rgb_to_hsv_pixel_top.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top
// Converts one 8-bit RGB pixel per clock to hue in degrees, saturation
// on 0..255 and brightness (the largest channel).
//
// Input: a pixel beat (red, green, blue) is taken at a rising edge where
// start is high and busy is low. busy rises only if the queue between the
// classifier and the divider pipeline is full, which the divider, taking
// one beat every cycle, never lets happen; a new pixel may follow in every
// cycle.
// Output: each result beat (hue, saturation, brightness) is on the ports
// for one cycle with strobe high, in input order. Throughput is one pixel
// per cycle. A pixel passes the classifier register, the queue entry, the
// eight divider pipeline stages (one quotient bit per stage) and the result
// register, in that order.
// The receiver cannot stall, so the pipeline never holds.
// Reset (rst, synchronous) empties the queue and drops all beats in flight.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [rthsv_pkg::CH_W-1:0]  red,
  input  logic [rthsv_pkg::CH_W-1:0]  green,
  input  logic [rthsv_pkg::CH_W-1:0]  blue,
  output logic                        strobe,
  output logic [rthsv_pkg::HUE_W-1:0] hue,
  output logic [rthsv_pkg::CH_W-1:0]  saturation,
  output logic [rthsv_pkg::CH_W-1:0]  brightness
);
  import rthsv_pkg::*;

  logic        accept;
  logic        item_valid;
  item_t       item;
  item_t       head;
  queue_stat_t qstat;

  assign accept = start && !busy;

  // classifier
  rthsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .qstat      (qstat),
    .busy       (busy),
    .item_valid (item_valid),
    .item       (item)
  );

  // decoupling queue
  rthsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (item_valid),
    .push_item  (item),
    .qstat      (qstat),
    .head       (head)
  );

  // divider pipeline and result register
  rthsv_divpipe u_divpipe (
    .clk        (clk),
    .rst        (rst),
    .head_valid (qstat.not_empty),
    .head       (head),
    .strobe     (strobe),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule

/* src/rthsv_checker.sv */
// ----------------------------------------------------------------------------
// rthsv_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rthsv_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       strobe,
  input logic [8:0] hue,
  input logic [7:0] saturation,
  input logic [7:0] brightness
);

  // every taken pixel gives exactly one result beat
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##11 strobe)
    else $error("result beat missing after a taken pixel");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##11 !strobe)
    else $error("result beat without a taken pixel");

  // hue stays within one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (hue < 9'd360))
    else $error("hue out of range");

  // zero saturation only for a gray pixel, which has zero hue
  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    (strobe && saturation == 8'd0) |-> (hue == 9'd0))
    else $error("gray pixel with non-zero hue");

  // brightness is one of the channels of the matching pixel
  a_value_channel: assert property (@(posedge clk) disable iff (rst)
    (strobe && $past(start && !busy, 11)) |->
      (brightness == $past(red, 11) || brightness == $past(green, 11) ||
       brightness == $past(blue, 11)))
    else $error("brightness is not a channel of its pixel");

endmodule

bind rgb_to_hsv_pixel_top rthsv_checker u_checker (.*);

/* tb/tb_rgb_to_hsv_pixel_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_pixel_top
// Self-checking bench for the RGB to HSV pixel converter. Pixel beats go in
// with random gaps, first a directed set of corner pixels, then random and
// shaped pixels. Every result beat is checked field by field against a
// predicted HSV value in input order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel_top;
  import rthsv_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_PIXELS = 850;
  localparam int DRAIN_CYCLES  = 30;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_t;

  // expected hsv beats in input order, checked against the output strobe
  class hsv_scoreboard;
    hsv_t pending_hsv[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // integer hsv with round half up and the hue wrapped below 360
    static function hsv_t predict_hsv(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                      logic [CH_W-1:0] b);
      int   ri, gi, bi, mx, mn, d, diff, base, num, h;
      hsv_t res;
      ri = r;
      gi = g;
      bi = b;
      mx = (ri > gi) ? ri : gi;
      mx = (mx > bi) ? mx : bi;
      mn = (ri < gi) ? ri : gi;
      mn = (mn < bi) ? mn : bi;
      d  = mx - mn;
      h  = 0;
      res.val = mx[CH_W-1:0];
      res.sat = '0;
      if (mx != 0) begin
        res.sat = CH_W'((510 * d + mx) / (2 * mx));
      end
      if (d != 0) begin
        // red wins ties over green, green over blue
        if (ri == mx) begin
          diff = gi - bi;
          base = (diff >= 0) ? 0 : 360;
        end else if (gi == mx) begin
          diff = bi - ri;
          base = 120;
        end else begin
          diff = ri - gi;
          base = 240;
        end
        num = 2 * base * d + 120 * diff + d;
        h   = num / (2 * d);
        if (h >= 360) h -= 360;
      end
      res.hue = h[HUE_W-1:0];
      return res;
    endfunction

    function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b);
      pending_hsv.push_back(predict_hsv(r, g, b));
    endfunction

    function void check_beat(hsv_t got);
      hsv_t exp_hsv;
      if (pending_hsv.size() == 0) begin
        $error("result beat with nothing pending: hue %0d sat %0d val %0d",
               got.hue, got.sat, got.val);
        errors++;
        return;
      end
      exp_hsv = pending_hsv.pop_front();
      if (got.hue !== exp_hsv.hue) begin
        $error("hue: expected %0d, actual %0d", exp_hsv.hue, got.hue);
        errors++;
      end
      if (got.sat !== exp_hsv.sat) begin
        $error("saturation: expected %0d, actual %0d", exp_hsv.sat, got.sat);
        errors++;
      end
      if (got.val !== exp_hsv.val) begin
        $error("brightness: expected %0d, actual %0d", exp_hsv.val, got.val);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [CH_W-1:0]  red = '0;
  logic [CH_W-1:0]  green = '0;
  logic [CH_W-1:0]  blue = '0;
  logic             strobe;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  brightness;

  hsv_scoreboard hsv_sb = new();
  int            cycle_count = 0;
  int            burst_left = 0;
  bit            burst_no_gap = 0;

  rgb_to_hsv_pixel_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .strobe     (strobe),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  // clock
  always #HALF_PERIOD clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // note accepted pixels, then check result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) hsv_sb.note_pixel(red, green, blue);
      if (strobe) hsv_sb.check_beat('{hue: hue, sat: saturation, val: brightness});
    end
  end

  // gap before the next pixel, with bursts of back-to-back beats
  function automatic int draw_gap();
    if (burst_left == 0) begin
      burst_left   = $urandom_range(1, 40);
      burst_no_gap = ($urandom_range(0, 3) == 0);
    end
    burst_left--;
    return burst_no_gap ? 0 : $urandom_range(0, 19);
  endfunction

  // drive one pixel beat and hold it until taken
  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                            logic [CH_W-1:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    do @(posedge clk); while (busy);
  endtask

  // random pixel: uniform, or with grays, ties, extremes, near-equal or low channels
  task automatic send_random_pixel();
    logic [CH_W-1:0] r, g, b, lvl;
    r   = CH_W'($urandom);
    g   = CH_W'($urandom);
    b   = CH_W'($urandom);
    lvl = CH_W'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        g = r;
        b = r;
      end
      1: g = r;
      2: b = g;
      3: b = r;
      4: begin
        r = $urandom_range(0, 1) ? 8'hff : 8'h00;
        g = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      5: begin
        // near-equal channels give small differences and hue near a wrap
        g = r - CH_W'($urandom_range(0, 2));
        b = r - CH_W'($urandom_range(0, 2));
      end
      6: begin
        r = lvl & CH_W'($urandom_range(0, 7));
        g = lvl & CH_W'($urandom_range(0, 7));
        b = lvl & CH_W'($urandom_range(0, 7));
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corner pixels
    send_pixel(8'd0,   8'd0,   8'd0);    // black
    send_pixel(8'd255, 8'd255, 8'd255);  // white
    send_pixel(8'd128, 8'd128, 8'd128);  // mid gray
    send_pixel(8'd255, 8'd0,   8'd0);    // pure red
    send_pixel(8'd0,   8'd255, 8'd0);    // pure green
    send_pixel(8'd0,   8'd0,   8'd255);  // pure blue
    send_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
    send_pixel(8'd0,   8'd255, 8'd255);  // green and blue tie
    send_pixel(8'd255, 8'd0,   8'd255);  // red and blue tie
    send_pixel(8'd255, 8'd0,   8'd1);    // hue rounds to 360, wraps
    send_pixel(8'd200, 8'd10,  8'd11);   // red max, green below blue
    send_pixel(8'd1,   8'd0,   8'd0);    // smallest non-black
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd255, 8'd254, 8'd253);  // low saturation
    send_pixel(8'd254, 8'd255, 8'd253);
    send_pixel(8'd253, 8'd254, 8'd255);
    send_pixel(8'haa,  8'h55,  8'haa);
    send_pixel(8'h55,  8'haa,  8'h55);
    send_pixel(8'd85,  8'd170, 8'd255);
    send_pixel(8'd3,   8'd2,   8'd1);    // small descending channels
    send_pixel(8'd100, 8'd50,  8'd0);

    // random pixels
    repeat (RANDOM_PIXELS) send_random_pixel();
    start <= 1'b0;

    // drain, then watch for stray beats
    while (hsv_sb.pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (hsv_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* rgb_to_hsv_pixel_top.f */
src/rthsv_pkg.sv
src/rthsv_front.sv
src/rthsv_queue.sv
src/rthsv_divpipe.sv
src/rgb_to_hsv_pixel_top.sv
src/rthsv_checker.sv
tb/tb_rgb_to_hsv_pixel_top.sv
